@@ hw/rtl/can_text_line_parser_core_defines.svh @@
// Assertion macros for the CAN text line parser checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef CAN_TEXT_LINE_PARSER_CORE_DEFINES_SVH
`define CAN_TEXT_LINE_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CTLP_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("ctlp check failed");

// next-cycle implication, checked outside reset
`define CTLP_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("ctlp check failed");

`endif

@@ hw/rtl/ctlp_pkg.sv @@
// Package for the CAN text line parser: character codes, field numbers,
// shared types and the digit decode function. No dependencies.
package ctlp_pkg;

  localparam int MAX_DATA_BYTES = 8;
  localparam int OUT_BYTES      = 8;

  localparam logic [7:0] CHAR_M     = 8'h6D;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [3:0] FLD_TIME = 4'd1;
  localparam logic [3:0] FLD_ID   = 4'd2;
  localparam logic [3:0] FLD_LEN  = 4'd3;
  localparam logic [3:0] FLD_DATA = 4'd4;
  localparam logic [3:0] FLD_LAST = 4'(4 + MAX_DATA_BYTES);

  localparam logic [1:0] BYTE_DIGITS = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } char_stage_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // hex selects base 16, otherwise base 10
  function automatic digit_t digit_of(logic [7:0] c, logic hex);
    digit_t d;
    d.ok  = 1'b0;
    d.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.ok  = 1'b1;
      d.val = 4'(c - 8'h30);
    end else if (hex && c >= 8'h61 && c <= 8'h66) begin
      d.ok  = 1'b1;
      d.val = 4'(c - 8'h61 + 8'd10);
    end else if (hex && c >= 8'h41 && c <= 8'h46) begin
      d.ok  = 1'b1;
      d.val = 4'(c - 8'h41 + 8'd10);
    end
    return d;
  endfunction

endpackage

@@ hw/rtl/ctlp_char_if.sv @@
// Character channel: valid/ready handshake carrying one ASCII character.
// Depends on nothing.
interface ctlp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

@@ hw/rtl/ctlp_frame_if.sv @@
// Frame channel: valid/ready handshake carrying one parsed CAN frame.
// Depends on nothing.
interface ctlp_frame_if;
  logic        valid;
  logic        ready;
  logic [31:0] timestamp;
  logic [31:0] identifier;
  logic [3:0]  frame_length;
  logic [7:0]  byte_0;
  logic [7:0]  byte_1;
  logic [7:0]  byte_2;
  logic [7:0]  byte_3;
  logic [7:0]  byte_4;
  logic [7:0]  byte_5;
  logic [7:0]  byte_6;
  logic [7:0]  byte_7;
  logic [3:0]  bytes_present;

  modport source (output valid, output timestamp, output identifier, output frame_length,
                  output byte_0, output byte_1, output byte_2, output byte_3,
                  output byte_4, output byte_5, output byte_6, output byte_7,
                  output bytes_present, input ready);
  modport sink   (input valid, input timestamp, input identifier, input frame_length,
                  input byte_0, input byte_1, input byte_2, input byte_3,
                  input byte_4, input byte_5, input byte_6, input byte_7,
                  input bytes_present, output ready);
endinterface

@@ hw/rtl/ctlp_in_stage.sv @@
// Input register of the CAN text line parser.
// Depends on ctlp_pkg and ctlp_char_if.
module ctlp_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  ctlp_char_if.sink            in_chan,
  input  logic                 consume,
  output ctlp_pkg::char_stage_t stage
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] ch_r;
  logic       load;

  assign in_chan.ready = !valid_r || consume;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch_r <= in_chan.character;
    end
  end

  assign stage.valid = valid_r;
  assign stage.ch    = ch_r;

endmodule

@@ hw/rtl/ctlp_parser.sv @@
// Line parser state and frame output register of the CAN text line parser.
// Depends on ctlp_pkg and ctlp_frame_if.
module ctlp_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctlp_pkg::char_stage_t stage,
  output logic                  consume,
  ctlp_frame_if.source          out_chan
);

  localparam int NB = ctlp_pkg::MAX_DATA_BYTES;
  localparam int NO = ctlp_pkg::OUT_BYTES;

  logic        in_line_r, in_line_nxt;
  logic [3:0]  fn_r, fn_nxt;
  logic [1:0]  dc_r, dc_nxt;
  logic [31:0] fv_r, fv_nxt;
  logic        stop_r, stop_nxt;
  logic [31:0] time_r, time_nxt;
  logic [31:0] id_r, id_nxt;
  logic [3:0]  len_r, len_nxt;
  logic [7:0]  data_r [NB];
  logic [7:0]  data_nxt [NB];
  logic [3:0]  cnt_r, cnt_nxt;

  // values as they stand once the open field is committed
  logic [31:0] cm_time, cm_id;
  logic [3:0]  cm_len, cm_cnt;
  logic [7:0]  cm_data [NB];
  logic        data_fld;

  logic          out_v_r, out_v_nxt;
  logic [31:0]   out_time_r, out_id_r;
  logic [3:0]    out_len_r, out_cnt_r;
  logic [7:0]    out_byte_r [NO];
  logic [7:0]    out_byte_nxt [NO];

  logic             go;
  logic             emit;
  logic             hex;
  ctlp_pkg::digit_t dig;
  logic [7:0]       c;

  assign c       = stage.ch;
  assign consume = stage.valid && (!out_v_r || out_chan.ready);
  assign go      = consume;

  assign data_fld = (fn_r >= ctlp_pkg::FLD_DATA) && (fn_r < ctlp_pkg::FLD_LAST);
  // time and length digits are decimal, the rest hex
  assign hex      = (fn_r != ctlp_pkg::FLD_TIME) && (fn_r != ctlp_pkg::FLD_LEN);
  assign dig      = ctlp_pkg::digit_of(c, hex);

  always_comb begin
    cm_time = (fn_r == ctlp_pkg::FLD_TIME) ? fv_r : time_r;
    cm_id   = (fn_r == ctlp_pkg::FLD_ID) ? fv_r : id_r;
    cm_len  = (fn_r == ctlp_pkg::FLD_LEN) ? fv_r[3:0] : len_r;
    for (int i = 0; i < NB; i++) begin
      cm_data[i] = ((fn_r == 4'(4 + i)) && (dc_r == ctlp_pkg::BYTE_DIGITS)) ?
                   fv_r[7:0] : data_r[i];
    end
    cm_cnt = cnt_r + {3'd0, (data_fld && (dc_r == ctlp_pkg::BYTE_DIGITS))};
  end

  always_comb begin
    in_line_nxt = in_line_r;
    fn_nxt      = fn_r;
    dc_nxt      = dc_r;
    fv_nxt      = fv_r;
    stop_nxt    = stop_r;
    time_nxt    = time_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    data_nxt    = data_r;
    cnt_nxt     = cnt_r;
    emit        = 1'b0;
    if (go) begin
      priority if (c == ctlp_pkg::CHAR_M) begin
        in_line_nxt = 1'b1;
        fn_nxt      = 4'd0;
        dc_nxt      = 2'd0;
        fv_nxt      = 32'd0;
        stop_nxt    = 1'b0;
        time_nxt    = 32'd0;
        id_nxt      = 32'd0;
        len_nxt     = 4'd0;
        cnt_nxt     = 4'd0;
        for (int i = 0; i < NB; i++) begin
          data_nxt[i] = 8'd0;
        end
      end else if (!in_line_r || c == ctlp_pkg::CHAR_LF) begin
        // ignored
      end else if (c == ctlp_pkg::CHAR_CR) begin
        emit        = 1'b1;
        in_line_nxt = 1'b0;
      end else if (c == ctlp_pkg::CHAR_SPACE) begin
        time_nxt = cm_time;
        id_nxt   = cm_id;
        len_nxt  = cm_len;
        data_nxt = cm_data;
        cnt_nxt  = cm_cnt;
        if (fn_r < ctlp_pkg::FLD_LAST) begin
          fn_nxt = fn_r + 4'd1;
        end
        dc_nxt   = 2'd0;
        fv_nxt   = 32'd0;
        stop_nxt = 1'b0;
      end else if (fn_r == ctlp_pkg::FLD_LEN) begin
        if (dc_r == 2'd0) begin
          fv_nxt = dig.ok ? {28'd0, dig.val} : 32'd0;
          dc_nxt = 2'd1;
        end
      end else if ((fn_r == ctlp_pkg::FLD_TIME) || (fn_r == ctlp_pkg::FLD_ID) ||
                   (data_fld && dc_r < ctlp_pkg::BYTE_DIGITS)) begin
        if (!stop_r) begin
          if (!dig.ok) begin
            stop_nxt = 1'b1;
          end else if (hex) begin
            fv_nxt = {fv_r[27:0], dig.val};
          end else begin
            fv_nxt = {fv_r[28:0], 3'd0} + {fv_r[30:0], 1'b0} + {28'd0, dig.val};
          end
        end
        if (data_fld) begin
          dc_nxt = dc_r + 2'd1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NO; i++) begin
      out_byte_nxt[i] = 8'd0;
      if (i < NB) begin
        out_byte_nxt[i] = cm_data[i];
      end
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (go && emit) begin
      out_v_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_line_r <= 1'b0;
      fn_r      <= 4'd0;
      dc_r      <= 2'd0;
      fv_r      <= 32'd0;
      stop_r    <= 1'b0;
      time_r    <= 32'd0;
      id_r      <= 32'd0;
      len_r     <= 4'd0;
      cnt_r     <= 4'd0;
      for (int i = 0; i < NB; i++) begin
        data_r[i] <= 8'd0;
      end
      out_v_r   <= 1'b0;
    end else begin
      in_line_r <= in_line_nxt;
      fn_r      <= fn_nxt;
      dc_r      <= dc_nxt;
      fv_r      <= fv_nxt;
      stop_r    <= stop_nxt;
      time_r    <= time_nxt;
      id_r      <= id_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      data_r    <= data_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      out_time_r <= cm_time;
      out_id_r   <= cm_id;
      out_len_r  <= cm_len;
      out_cnt_r  <= cm_cnt;
      out_byte_r <= out_byte_nxt;
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.timestamp     = out_time_r;
  assign out_chan.identifier    = out_id_r;
  assign out_chan.frame_length  = out_len_r;
  assign out_chan.byte_0        = out_byte_r[0];
  assign out_chan.byte_1        = out_byte_r[1];
  assign out_chan.byte_2        = out_byte_r[2];
  assign out_chan.byte_3        = out_byte_r[3];
  assign out_chan.byte_4        = out_byte_r[4];
  assign out_chan.byte_5        = out_byte_r[5];
  assign out_chan.byte_6        = out_byte_r[6];
  assign out_chan.byte_7        = out_byte_r[7];
  assign out_chan.bytes_present = out_cnt_r;

endmodule

@@ hw/rtl/can_text_line_parser_core.sv @@
// CAN text line parser: one character per transaction in, one frame per carriage return that ends an 'm' line out.
// A carriage return passes the input register, then the frame output register, before its frame shows valid.
// Throughput: one character per cycle while no frame is stalled in the output register.
// While a frame waits in the output register, at most one more character is taken, then input stalls.
// Reset (synchronous, rst_n low) empties both registers and returns to waiting for 'm'.
module can_text_line_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  ctlp_char_if.sink    in_chan,
  ctlp_frame_if.source out_chan
);

  ctlp_pkg::char_stage_t stage;
  logic                  consume;

  ctlp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .consume (consume),
    .stage   (stage)
  );

  ctlp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .stage    (stage),
    .consume  (consume),
    .out_chan (out_chan)
  );

endmodule

@@ hw/rtl/ctlp_checker.sv @@
// Port-level checks for can_text_line_parser_core, bound to the top level.
// Depends on can_text_line_parser_core_defines.svh.
`include "can_text_line_parser_core_defines.svh"

module ctlp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_timestamp,
  input logic [31:0] out_identifier,
  input logic [3:0]  out_frame_length,
  input logic [3:0]  out_bytes_present
);

  // a stalled frame keeps its valid, timestamp, identifier and byte count
  `CTLP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_timestamp) && $stable(out_identifier) && $stable(out_bytes_present))

  // input only stalls behind a stalled frame
  `CTLP_ASSERT_IMP(a_in_stall, in_valid && !in_ready, out_valid && !out_ready)

  `CTLP_ASSERT_IMP(a_count_max, out_valid, out_bytes_present <= 4'd8)

  `CTLP_ASSERT_IMP(a_len_digit, out_valid, out_frame_length <= 4'd9)

endmodule

bind can_text_line_parser_core ctlp_checker u_ctlp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_timestamp     (out_chan.timestamp),
  .out_identifier    (out_chan.identifier),
  .out_frame_length  (out_chan.frame_length),
  .out_bytes_present (out_chan.bytes_present)
);
